// File: design/lut3d_color_grade_diagonal_macros.svh
// Assertion macros shared by the checker of the 3D color grading block.
// No dependencies; included by files that hold concurrent assertions.
`ifndef LUT3D_COLOR_GRADE_DIAGONAL_MACROS_SVH
`define LUT3D_COLOR_GRADE_DIAGONAL_MACROS_SVH

// The consequent must hold at the next clock edge after the antecedent.
`define L3DCG_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("l3dcg: next-cycle check failed");

// The consequent must hold at the same clock edge as the antecedent.
`define L3DCG_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("l3dcg: same-cycle check failed");

`endif

// File: design/l3dcg_pkg.sv
// Types, constants and helper functions of the 3D color grading block.
// No dependencies; imported by every module of the block but l3dcg_ram.
package l3dcg_pkg;

   localparam int L3DCG_TABLE_DIM   = 32;
   localparam int L3DCG_ENTRY_BITS  = 13;
   localparam int L3DCG_IDX_BITS    = $clog2(L3DCG_TABLE_DIM);
   localparam int L3DCG_ADDR_BITS   = 3 * L3DCG_IDX_BITS;
   localparam int L3DCG_TABLE_SIZE  = L3DCG_TABLE_DIM * L3DCG_TABLE_DIM * L3DCG_TABLE_DIM;
   localparam int L3DCG_CHANNELS    = 3;
   localparam int L3DCG_PIXEL_BITS  = 8;
   localparam int L3DCG_FRAC_BITS   = 3;
   localparam int L3DCG_GAIN_BITS   = 8;
   localparam int L3DCG_QUEUE_DEPTH = 4;
   localparam int L3DCG_QPTR_BITS   = $clog2(L3DCG_QUEUE_DEPTH);
   localparam int L3DCG_CSR_ADDR_BITS = 3;
   localparam int L3DCG_CSR_DATA_BITS = 32;

   localparam logic [L3DCG_IDX_BITS-1:0] L3DCG_IDX_MAX =
      L3DCG_IDX_BITS'(L3DCG_TABLE_DIM - 2);
   localparam logic [L3DCG_FRAC_BITS:0] L3DCG_FRAC_ONE =
      (L3DCG_FRAC_BITS + 1)'(1 << L3DCG_FRAC_BITS);
   localparam logic [L3DCG_GAIN_BITS-1:0] L3DCG_GAIN_RESET = L3DCG_GAIN_BITS'(64);
   localparam logic [L3DCG_PIXEL_BITS-1:0] L3DCG_OUT_MAX = '1;

   // Register index as seen in bit 2 of the byte address.
   localparam logic L3DCG_CSR_GAIN = 1'b0;

   typedef enum logic {
      REQ_WRITE = 1'b0,
      REQ_PIXEL = 1'b1
   } l3dcg_req_type;

   // One queued command: a table write (start_addr is the entry address)
   // or a pixel with both table addresses and the channel fractions.
   typedef struct packed {
      logic                                             is_pixel;
      logic [L3DCG_ADDR_BITS-1:0]                       start_addr;
      logic [L3DCG_ADDR_BITS-1:0]                       end_addr;
      logic [L3DCG_CHANNELS-1:0][L3DCG_FRAC_BITS-1:0]   frac;
   } l3dcg_cmd_type;

   // Table index of one channel; the last cell is folded onto the one below
   // so that the end entry stays inside the table.
   function automatic logic [L3DCG_IDX_BITS-1:0] l3dcg_chan_index(
      input logic [L3DCG_PIXEL_BITS-1:0] c);
      logic [L3DCG_IDX_BITS-1:0] idx;
      idx = c[L3DCG_PIXEL_BITS-1 -: L3DCG_IDX_BITS];
      if (idx > L3DCG_IDX_MAX) begin
         idx = L3DCG_IDX_MAX;
      end
      return idx;
   endfunction

endpackage

// File: design/l3dcg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the copies of the color table.
module l3dcg_ram #(
   parameter int WIDTH = 39,
   parameter int DEPTH = 32768
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/l3dcg_front.sv
// Front end: accepts request items, works out table addresses and fractions,
// and queues commands for the back end. Depends on l3dcg_pkg.
module l3dcg_front import l3dcg_pkg::*; #(
   parameter int ENTRY_BITS = L3DCG_ENTRY_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [0:0]                         req_type,
   input  logic [L3DCG_ADDR_BITS-1:0]         req_entry_index,
   input  logic [ENTRY_BITS-1:0]              req_entry_red,
   input  logic [ENTRY_BITS-1:0]              req_entry_green,
   input  logic [ENTRY_BITS-1:0]              req_entry_blue,
   input  logic [L3DCG_PIXEL_BITS-1:0]        req_pixel_red,
   input  logic [L3DCG_PIXEL_BITS-1:0]        req_pixel_green,
   input  logic [L3DCG_PIXEL_BITS-1:0]        req_pixel_blue,
   output logic                               cmd_valid,
   input  logic                               cmd_pop,
   output l3dcg_cmd_type                      cmd,
   output logic [L3DCG_CHANNELS*ENTRY_BITS-1:0] cmd_data
);

   localparam int DataBits = L3DCG_CHANNELS * ENTRY_BITS;

   l3dcg_cmd_type              cmd_q_ff  [L3DCG_QUEUE_DEPTH];
   logic [DataBits-1:0]        data_q_ff [L3DCG_QUEUE_DEPTH];
   logic [L3DCG_QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [L3DCG_QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [L3DCG_QPTR_BITS:0]   count_ff, count_in;

   logic [L3DCG_IDX_BITS-1:0]  idx_r, idx_g, idx_b;
   l3dcg_cmd_type              new_cmd;
   logic                       push;

   always_comb begin
      idx_r = l3dcg_chan_index(req_pixel_red);
      idx_g = l3dcg_chan_index(req_pixel_green);
      idx_b = l3dcg_chan_index(req_pixel_blue);
      new_cmd.is_pixel = (req_type == REQ_PIXEL);
      if (req_type == REQ_PIXEL) begin
         new_cmd.start_addr = {idx_b, idx_g, idx_r};
      end else begin
         new_cmd.start_addr = req_entry_index;
      end
      // The end entry lies one step further along all three axes.
      new_cmd.end_addr = {L3DCG_IDX_BITS'(idx_b + 1'b1),
                          L3DCG_IDX_BITS'(idx_g + 1'b1),
                          L3DCG_IDX_BITS'(idx_r + 1'b1)};
      new_cmd.frac[0] = req_pixel_red[L3DCG_FRAC_BITS-1:0];
      new_cmd.frac[1] = req_pixel_green[L3DCG_FRAC_BITS-1:0];
      new_cmd.frac[2] = req_pixel_blue[L3DCG_FRAC_BITS-1:0];
   end

   assign req_stall = (count_ff == (L3DCG_QPTR_BITS + 1)'(L3DCG_QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (count_ff != '0);
   assign cmd       = cmd_q_ff[rd_ptr_ff];
   assign cmd_data  = data_q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? L3DCG_QPTR_BITS'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? L3DCG_QPTR_BITS'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !cmd_pop) begin
         count_in = (L3DCG_QPTR_BITS + 1)'(count_ff + 1'b1);
      end else if (!push && cmd_pop) begin
         count_in = (L3DCG_QPTR_BITS + 1)'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         cmd_q_ff[wr_ptr_ff]  <= new_cmd;
         data_q_ff[wr_ptr_ff] <= {req_entry_blue, req_entry_green, req_entry_red};
      end
   end

endmodule

// File: design/l3dcg_back.sv
// Back end: table storage, trilinear-diagonal blend, gain and saturation.
// Depends on l3dcg_pkg and l3dcg_ram.
module l3dcg_back import l3dcg_pkg::*; #(
   parameter int ENTRY_BITS = L3DCG_ENTRY_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 cmd_valid,
   output logic                                 cmd_pop,
   input  l3dcg_cmd_type                        cmd,
   input  logic [L3DCG_CHANNELS*ENTRY_BITS-1:0] cmd_data,
   input  logic [L3DCG_GAIN_BITS-1:0]           gain,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [L3DCG_PIXEL_BITS-1:0]          rsp_graded_red,
   output logic [L3DCG_PIXEL_BITS-1:0]          rsp_graded_green,
   output logic [L3DCG_PIXEL_BITS-1:0]          rsp_graded_blue
);

   localparam int DataBits = L3DCG_CHANNELS * ENTRY_BITS;
   localparam int SumBits  = ENTRY_BITS + L3DCG_FRAC_BITS;
   localparam int ProdBits = SumBits + L3DCG_GAIN_BITS;
   localparam int OutShift = L3DCG_FRAC_BITS + ENTRY_BITS - 1;

   logic                enable;
   logic                ram_wr, ram_rd;
   logic [DataBits-1:0] start_data, end_data;

   logic                                           s1_valid_ff, s1_valid_in;
   logic [L3DCG_CHANNELS-1:0][L3DCG_FRAC_BITS-1:0] s1_frac_ff;
   logic                                           s2_valid_ff;
   logic [SumBits-1:0]                             s2_sum_ff  [L3DCG_CHANNELS];
   logic [SumBits-1:0]                             s2_sum_in  [L3DCG_CHANNELS];
   logic                                           s3_valid_ff;
   logic [ProdBits-1:0]                            s3_prod_ff [L3DCG_CHANNELS];
   logic [L3DCG_PIXEL_BITS-1:0]                    out_in     [L3DCG_CHANNELS];
   logic                                           rsp_valid_ff;
   logic [L3DCG_PIXEL_BITS-1:0]                    graded_ff  [L3DCG_CHANNELS];

   // start*(8-f) + end*f, which is eight times the interpolated value.
   function automatic logic [SumBits-1:0] blend(
      input logic [ENTRY_BITS-1:0]      s,
      input logic [ENTRY_BITS-1:0]      e,
      input logic [L3DCG_FRAC_BITS-1:0] f);
      logic [SumBits:0] ps, pe, sum;
      ps  = {{(L3DCG_FRAC_BITS + 1){1'b0}}, s} *
            {{ENTRY_BITS{1'b0}}, L3DCG_FRAC_ONE - {1'b0, f}};
      pe  = {{(L3DCG_FRAC_BITS + 1){1'b0}}, e} * {{(ENTRY_BITS + 1){1'b0}}, f};
      sum = ps + pe;
      return sum[SumBits-1:0];
   endfunction

   // The whole pipeline moves together whenever the output register is free.
   assign enable  = !rsp_valid_ff || !rsp_stall;
   assign cmd_pop = cmd_valid && enable;
   assign ram_wr  = cmd_pop && !cmd.is_pixel;
   assign ram_rd  = cmd_pop && cmd.is_pixel;
   assign s1_valid_in = ram_rd;

   // Two copies of the table so that start and end are read in the same cycle.
   l3dcg_ram #(
      .WIDTH (DataBits),
      .DEPTH (L3DCG_TABLE_SIZE)
   ) u_start_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (cmd.start_addr),
      .wr_data (cmd_data),
      .rd_en   (ram_rd),
      .rd_addr (cmd.start_addr),
      .rd_data (start_data)
   );

   l3dcg_ram #(
      .WIDTH (DataBits),
      .DEPTH (L3DCG_TABLE_SIZE)
   ) u_end_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (cmd.start_addr),
      .wr_data (cmd_data),
      .rd_en   (ram_rd),
      .rd_addr (cmd.end_addr),
      .rd_data (end_data)
   );

   always_comb begin
      for (int k = 0; k < L3DCG_CHANNELS; k++) begin
         s2_sum_in[k] = blend(start_data[k*ENTRY_BITS +: ENTRY_BITS],
                              end_data[k*ENTRY_BITS +: ENTRY_BITS],
                              s1_frac_ff[k]);
         if (s3_prod_ff[k][ProdBits-1 -: (L3DCG_PIXEL_BITS + 1)] > 
             {1'b0, L3DCG_OUT_MAX}) begin
            out_in[k] = L3DCG_OUT_MAX;
         end else begin
            out_in[k] = s3_prod_ff[k][OutShift +: L3DCG_PIXEL_BITS];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         if (s1_valid_in) begin
            s1_frac_ff <= cmd.frac;
         end
         for (int k = 0; k < L3DCG_CHANNELS; k++) begin
            if (s1_valid_ff) begin
               s2_sum_ff[k] <= s2_sum_in[k];
            end
            if (s2_valid_ff) begin
               s3_prod_ff[k] <= {{L3DCG_GAIN_BITS{1'b0}}, s2_sum_ff[k]} *
                                {{SumBits{1'b0}}, gain};
            end
            if (s3_valid_ff) begin
               graded_ff[k] <= out_in[k];
            end
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_graded_red   = graded_ff[0];
   assign rsp_graded_green = graded_ff[1];
   assign rsp_graded_blue  = graded_ff[2];

endmodule

// File: design/lut3d_color_grade_diagonal.sv
// 3D color grading block with a 32x32x32 table: the top level.
// Request items either load one table entry or grade one RGB pixel; each
// pixel reads a start entry and the entry one step along all three axes,
// blends each channel by the low three pixel bits, applies output_gain and
// saturates at 255. Table writes produce no result item.
// Channels use valid and stall; an item moves when valid is high and stall
// is low. output_gain sits at byte address 0 of the APB-style port.
// A pixel passes the command queue, the table read, blend, gain and output
// registers before it shows on rsp_valid. Throughput is one item per cycle
// while rsp_stall does not hold the pipeline, set by the single write and
// read ports of each table copy, so a write and a pixel cannot share a cycle.
// A four-entry command queue lets requests be accepted while a result waits;
// while a result item is held by rsp_stall the back pipeline holds, and
// req_stall rises once the queue is full.
// Reset empties the queue and the pipeline and sets output_gain to 64. The
// table is not cleared: every entry a pixel reads must be written first.
// Depends on l3dcg_pkg, l3dcg_front, l3dcg_back and l3dcg_ram.
module lut3d_color_grade_diagonal import l3dcg_pkg::*; #(
   parameter int ENTRY_BITS = L3DCG_ENTRY_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [0:0]                     req_type,
   input  logic [L3DCG_ADDR_BITS-1:0]     req_entry_index,
   input  logic [ENTRY_BITS-1:0]          req_entry_red,
   input  logic [ENTRY_BITS-1:0]          req_entry_green,
   input  logic [ENTRY_BITS-1:0]          req_entry_blue,
   input  logic [L3DCG_PIXEL_BITS-1:0]    req_pixel_red,
   input  logic [L3DCG_PIXEL_BITS-1:0]    req_pixel_green,
   input  logic [L3DCG_PIXEL_BITS-1:0]    req_pixel_blue,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [L3DCG_PIXEL_BITS-1:0]    rsp_graded_red,
   output logic [L3DCG_PIXEL_BITS-1:0]    rsp_graded_green,
   output logic [L3DCG_PIXEL_BITS-1:0]    rsp_graded_blue,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [L3DCG_CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [L3DCG_CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [L3DCG_CSR_DATA_BITS-1:0] csr_prdata,
   output logic                           csr_pready
);

   logic [L3DCG_GAIN_BITS-1:0]             gain_ff, gain_in;
   logic                                   cmd_valid, cmd_pop;
   l3dcg_cmd_type                          cmd;
   logic [L3DCG_CHANNELS*ENTRY_BITS-1:0]   cmd_data;
   logic                                   gain_sel;

   // Bit 2 of the byte address picks the register; the low bits are ignored.
   assign gain_sel   = (csr_paddr[2] == L3DCG_CSR_GAIN);
   assign csr_pready = 1'b1;
   assign csr_prdata = gain_sel ?
      {{(L3DCG_CSR_DATA_BITS - L3DCG_GAIN_BITS){1'b0}}, gain_ff} : '0;

   always_comb begin
      gain_in = gain_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && gain_sel) begin
         gain_in = csr_pwdata[L3DCG_GAIN_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= L3DCG_GAIN_RESET;
      end else begin
         gain_ff <= gain_in;
      end
   end

   l3dcg_front #(
      .ENTRY_BITS (ENTRY_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_entry_index (req_entry_index),
      .req_entry_red   (req_entry_red),
      .req_entry_green (req_entry_green),
      .req_entry_blue  (req_entry_blue),
      .req_pixel_red   (req_pixel_red),
      .req_pixel_green (req_pixel_green),
      .req_pixel_blue  (req_pixel_blue),
      .cmd_valid       (cmd_valid),
      .cmd_pop         (cmd_pop),
      .cmd             (cmd),
      .cmd_data        (cmd_data)
   );

   l3dcg_back #(
      .ENTRY_BITS (ENTRY_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (cmd_valid),
      .cmd_pop          (cmd_pop),
      .cmd              (cmd),
      .cmd_data         (cmd_data),
      .gain             (gain_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_graded_red   (rsp_graded_red),
      .rsp_graded_green (rsp_graded_green),
      .rsp_graded_blue  (rsp_graded_blue)
   );

endmodule

// File: design/l3dcg_checker.sv
// Port-level checks for the 3D color grading block, bound to its top level.
// Depends on l3dcg_pkg and lut3d_color_grade_diagonal_macros.svh.
`include "lut3d_color_grade_diagonal_macros.svh"

module l3dcg_checker import l3dcg_pkg::*; (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [L3DCG_PIXEL_BITS-1:0]    rsp_graded_red,
   input logic [L3DCG_PIXEL_BITS-1:0]    rsp_graded_green,
   input logic [L3DCG_PIXEL_BITS-1:0]    rsp_graded_blue,
   input logic                           csr_psel,
   input logic                           csr_penable,
   input logic                           csr_pwrite,
   input logic [L3DCG_CSR_ADDR_BITS-1:0] csr_paddr,
   input logic [L3DCG_CSR_DATA_BITS-1:0] csr_pwdata,
   input logic [L3DCG_CSR_DATA_BITS-1:0] csr_prdata
);

   // A result item that is stalled stays offered.
   `L3DCG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // A stalled result item keeps its values.
   `L3DCG_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_graded_red) && $stable(rsp_graded_green) && $stable(rsp_graded_blue))

   // Reset leaves the queue empty and the pipeline drained.
   `L3DCG_ASSERT_SAME(a_reset_empty, clock, reset, $fell(reset), !req_stall && !rsp_valid)

   // A gain write is read back from the following cycle on.
   `L3DCG_ASSERT_NEXT(a_gain_readback, clock, reset, csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == L3DCG_CSR_GAIN), (csr_paddr[2] != L3DCG_CSR_GAIN) || (csr_prdata[L3DCG_GAIN_BITS-1:0] == $past(csr_pwdata[L3DCG_GAIN_BITS-1:0])))

endmodule

bind lut3d_color_grade_diagonal l3dcg_checker u_l3dcg_checker (.*);
